[hw/rtl/ums_pkg.sv]
// ----------------------------------------------------------------------------
// ums_pkg
// Shared types and constants for the unimodal maximum search controller.
// ----------------------------------------------------------------------------
package ums_pkg;

    localparam int ARG_WIDTH_DEF   = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    // APB register map, one register per 32-bit word
    localparam int PADDR_WIDTH = 3;
    localparam logic REG_RANGE_LOW  = 1'b0;
    localparam logic REG_RANGE_HIGH = 1'b1;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_GLEFT,
        PH_GRIGHT,
        PH_TERN
    } ums_phase_t;

endpackage

[hw/rtl/unimodal_max_search_top.sv]
// ----------------------------------------------------------------------------
// unimodal_max_search_top
// Controller that finds the maximum of an externally evaluated unimodal
// function over [range_low, range_high], with an APB register port.
// ----------------------------------------------------------------------------
// Every input transaction (a start or a function value) produces exactly one
// result transaction, registered and offered in the cycle after acceptance. A
// new transaction is accepted every cycle while the output register is empty
// or being drained in the same cycle, so while out_ready stays high the
// sustained rate is one per clock; the single output register sets that
// figure. Range registers are sampled when a start transaction is accepted.
module unimodal_max_search_top #(
    parameter int ARG_WIDTH   = ums_pkg::ARG_WIDTH_DEF,
    parameter int VALUE_WIDTH = ums_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ums_pkg::PADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic signed [VALUE_WIDTH-1:0]    value_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             request,
    output logic        [ARG_WIDTH-1:0]      probe_x,
    output logic        [ARG_WIDTH-1:0]      best_x,
    output logic signed [VALUE_WIDTH-1:0]    best_value
);

    logic [ARG_WIDTH-1:0]          range_low_reg, range_high_reg;
    logic                          cfg_wr;
    logic                          in_fire;
    logic                          out_valid_reg;
    logic                          request_reg;
    logic        [ARG_WIDTH-1:0]   probe_x_reg, best_x_reg;
    logic signed [VALUE_WIDTH-1:0] best_value_reg;
    logic                          res_request;
    logic        [ARG_WIDTH-1:0]   res_probe_x, res_best_x;
    logic signed [VALUE_WIDTH-1:0] res_best_value;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                ums_pkg::REG_RANGE_LOW:  range_low_reg  <= pwdata[ARG_WIDTH-1:0];
                ums_pkg::REG_RANGE_HIGH: range_high_reg <= pwdata[ARG_WIDTH-1:0];
                default:                 range_low_reg  <= range_low_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[2])
            ums_pkg::REG_RANGE_LOW:  prdata = 32'(range_low_reg);
            ums_pkg::REG_RANGE_HIGH: prdata = 32'(range_high_reg);
            default:                 prdata = '0;
        endcase
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    ums_core #(
        .ARG_WIDTH   (ARG_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (in_fire),
        .kind       (kind),
        .value_in   (value_in),
        .range_low  (range_low_reg),
        .range_high (range_high_reg),
        .request    (res_request),
        .probe_x    (res_probe_x),
        .best_x     (res_best_x),
        .best_value (res_best_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            request_reg    <= res_request;
            probe_x_reg    <= res_probe_x;
            best_x_reg     <= res_best_x;
            best_value_reg <= res_best_value;
        end
    end

    assign out_valid  = out_valid_reg;
    assign request    = request_reg;
    assign probe_x    = probe_x_reg;
    assign best_x     = best_x_reg;
    assign best_value = best_value_reg;

endmodule

[hw/rtl/ums_core.sv]
// ----------------------------------------------------------------------------
// ums_core
// Search state registers and combinational step logic: start, end-point
// evaluation, left gallop, right gallop and ternary narrowing.
// ----------------------------------------------------------------------------
module ums_core #(
    parameter int ARG_WIDTH   = ums_pkg::ARG_WIDTH_DEF,
    parameter int VALUE_WIDTH = ums_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          kind,
    input  logic signed [VALUE_WIDTH-1:0] value_in,
    input  logic        [ARG_WIDTH-1:0]   range_low,
    input  logic        [ARG_WIDTH-1:0]   range_high,
    output logic                          request,
    output logic        [ARG_WIDTH-1:0]   probe_x,
    output logic        [ARG_WIDTH-1:0]   best_x,
    output logic signed [VALUE_WIDTH-1:0] best_value
);

    ums_pkg::ums_phase_t          phase_reg, phase_next;
    logic        [ARG_WIDTH-1:0]   lo_x_reg, lo_x_next;
    logic        [ARG_WIDTH-1:0]   hi_x_reg, hi_x_next;
    logic        [ARG_WIDTH-1:0]   mid_x_reg, mid_x_next;
    logic        [ARG_WIDTH-1:0]   pend_x_reg, pend_x_next;
    logic signed [VALUE_WIDTH-1:0] lo_v_reg, lo_v_next;
    logic signed [VALUE_WIDTH-1:0] hi_v_reg, hi_v_next;
    logic signed [VALUE_WIDTH-1:0] mid_v_reg, mid_v_next;
    logic                          pend_r_reg, pend_r_next;

    logic                          do_gl, do_gr, do_tern;
    logic                          ask_en, fin_en;
    logic        [ARG_WIDTH-1:0]   ask_x, fin_x, gr_x;
    ums_pkg::ums_phase_t          ask_ph;
    logic signed [VALUE_WIDTH-1:0] fin_v;
    logic        [ARG_WIDTH:0]     sum_lh, sum_mh, sum_lm;
    logic signed [ARG_WIDTH+1:0]   d_hm, d_ml;
    logic        [ARG_WIDTH-1:0]   t_x1, t_x2;
    logic signed [VALUE_WIDTH-1:0] t_v1, t_v2;

    always_comb
    begin
        phase_next  = phase_reg;
        lo_x_next   = lo_x_reg;
        lo_v_next   = lo_v_reg;
        hi_x_next   = hi_x_reg;
        hi_v_next   = hi_v_reg;
        mid_x_next  = mid_x_reg;
        mid_v_next  = mid_v_reg;
        pend_x_next = pend_x_reg;
        pend_r_next = pend_r_reg;
        do_gl   = 1'b0;
        do_gr   = 1'b0;
        do_tern = 1'b0;
        ask_en  = 1'b0;
        ask_x   = '0;
        ask_ph  = ums_pkg::PH_IDLE;
        fin_en  = 1'b0;
        fin_x   = '0;
        fin_v   = '0;
        sum_lh  = '0;
        sum_mh  = '0;
        sum_lm  = '0;
        gr_x    = '0;
        d_hm    = '0;
        d_ml    = '0;
        t_x1    = '0;
        t_x2    = '0;
        t_v1    = '0;
        t_v2    = '0;

        if (kind == ums_pkg::KIND_START)
        begin
            lo_x_next = range_low;
            hi_x_next = range_high;
            ask_en    = 1'b1;
            ask_x     = range_low;
            ask_ph    = ums_pkg::PH_LOW;
        end
        else
        begin
            case (phase_reg)
                ums_pkg::PH_LOW:
                begin
                    lo_v_next = value_in;
                    if (lo_x_reg == hi_x_reg)
                    begin
                        fin_en = 1'b1;
                        fin_x  = lo_x_reg;
                        fin_v  = value_in;
                    end
                    else
                    begin
                        ask_en = 1'b1;
                        ask_x  = hi_x_reg;
                        ask_ph = ums_pkg::PH_HIGH;
                    end
                end
                ums_pkg::PH_HIGH:
                begin
                    hi_v_next  = value_in;
                    mid_x_next = hi_x_reg;
                    mid_v_next = value_in;
                    do_gl      = 1'b1;
                end
                ums_pkg::PH_GLEFT:
                begin
                    mid_x_next = pend_x_reg;
                    mid_v_next = value_in;
                    if (value_in > lo_v_reg)
                    begin
                        do_gr = 1'b1;
                    end
                    else
                    begin
                        hi_x_next = pend_x_reg;
                        hi_v_next = value_in;
                        do_gl     = 1'b1;
                    end
                end
                ums_pkg::PH_GRIGHT:
                begin
                    mid_x_next = pend_x_reg;
                    mid_v_next = value_in;
                    do_gr      = 1'b1;
                end
                ums_pkg::PH_TERN:
                begin
                    if (pend_r_reg)
                    begin
                        t_x1 = mid_x_reg;
                        t_v1 = mid_v_reg;
                        t_x2 = pend_x_reg;
                        t_v2 = value_in;
                    end
                    else
                    begin
                        t_x1 = pend_x_reg;
                        t_v1 = value_in;
                        t_x2 = mid_x_reg;
                        t_v2 = mid_v_reg;
                    end
                    if (t_v1 < t_v2)
                    begin
                        lo_x_next  = t_x1;
                        lo_v_next  = t_v1;
                        mid_x_next = t_x2;
                        mid_v_next = t_v2;
                    end
                    else
                    begin
                        hi_x_next  = t_x2;
                        hi_v_next  = t_v2;
                        mid_x_next = t_x1;
                        mid_v_next = t_v1;
                    end
                    do_tern = 1'b1;
                end
                default:
                begin
                    fin_en = 1'b1;
                    fin_x  = mid_x_reg;
                    fin_v  = mid_v_reg;
                end
            endcase
        end

        // left gallop
        if (do_gl)
        begin
            sum_lh = {1'b0, lo_x_next} + {1'b0, hi_x_next};
            if (({1'b0, lo_x_next} + {{ARG_WIDTH{1'b0}}, 1'b1}) < {1'b0, hi_x_next})
            begin
                ask_en = 1'b1;
                ask_x  = sum_lh[ARG_WIDTH:1];
                ask_ph = ums_pkg::PH_GLEFT;
            end
            else if (mid_v_next <= lo_v_next)
            begin
                fin_en = 1'b1;
                fin_x  = lo_x_next;
                fin_v  = lo_v_next;
            end
            else
            begin
                do_gr = 1'b1;
            end
        end

        // right gallop
        if (do_gr)
        begin
            if (mid_v_next < hi_v_next)
            begin
                lo_x_next = mid_x_next;
                lo_v_next = mid_v_next;
                sum_mh    = {1'b0, mid_x_next} + {1'b0, hi_x_next};
                gr_x      = sum_mh[ARG_WIDTH:1];
                if (gr_x != mid_x_next)
                begin
                    ask_en = 1'b1;
                    ask_x  = gr_x;
                    ask_ph = ums_pkg::PH_GRIGHT;
                end
            end
            if (!ask_en)
            begin
                if (mid_v_next <= hi_v_next)
                begin
                    fin_en = 1'b1;
                    fin_x  = hi_x_next;
                    fin_v  = hi_v_next;
                end
                else
                begin
                    do_tern = 1'b1;
                end
            end
        end

        // ternary narrowing
        if (do_tern)
        begin
            if (({1'b0, lo_x_next} + {{(ARG_WIDTH-1){1'b0}}, 2'd2}) < {1'b0, hi_x_next})
            begin
                d_hm = $signed({2'b00, hi_x_next} - {2'b00, mid_x_next});
                d_ml = $signed({2'b00, mid_x_next} - {2'b00, lo_x_next});
                sum_mh = {1'b0, mid_x_next} + {1'b0, hi_x_next};
                sum_lm = {1'b0, lo_x_next} + {1'b0, mid_x_next};
                ask_en = 1'b1;
                ask_ph = ums_pkg::PH_TERN;
                if (d_hm > d_ml)
                begin
                    pend_r_next = 1'b1;
                    ask_x       = sum_mh[ARG_WIDTH:1];
                end
                else
                begin
                    pend_r_next = 1'b0;
                    ask_x       = sum_lm[ARG_WIDTH:1];
                end
            end
            else
            begin
                fin_en = 1'b1;
                fin_x  = mid_x_next;
                fin_v  = mid_v_next;
            end
        end

        if (ask_en)
        begin
            pend_x_next = ask_x;
            phase_next  = ask_ph;
        end
        else if (fin_en)
        begin
            mid_x_next = fin_x;
            mid_v_next = fin_v;
            phase_next = ums_pkg::PH_IDLE;
        end
    end

    assign request    = ask_en;
    assign probe_x    = ask_en ? ask_x : '0;
    assign best_x     = ask_en ? '0 : fin_x;
    assign best_value = ask_en ? '0 : fin_v;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= ums_pkg::PH_IDLE;
            lo_x_reg   <= '0;
            lo_v_reg   <= '0;
            hi_x_reg   <= '0;
            hi_v_reg   <= '0;
            mid_x_reg  <= '0;
            mid_v_reg  <= '0;
            pend_x_reg <= '0;
            pend_r_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            lo_x_reg   <= lo_x_next;
            lo_v_reg   <= lo_v_next;
            hi_x_reg   <= hi_x_next;
            hi_v_reg   <= hi_v_next;
            mid_x_reg  <= mid_x_next;
            mid_v_reg  <= mid_v_next;
            pend_x_reg <= pend_x_next;
            pend_r_reg <= pend_r_next;
        end
    end

endmodule
